FILE: hdl/tlik_pkg.sv
// Shared constants, register indexes and the CORDIC arctangent table
// for the two-link planar inverse kinematics unit. No dependencies.
package tlik_pkg;

    // Default fixed-point format and CORDIC depth
    localparam int FRAC_BITS_DEF     = 16;
    localparam int CORDIC_STAGES_DEF = 18;

    // CORDIC angle accumulator: 30 fraction bits, 34 bits wide
    localparam int ANG_FRAC = 30;
    localparam int ZW       = 34;
    localparam logic signed [ZW-1:0] PI_Q30 = 34'sd3373259426;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_OFFSET   = 3'd0,
        CFG_COLUMN_HEIGHT = 3'd1,
        CFG_UPPER_ARM     = 3'd2,
        CFG_FOREARM       = 3'd3,
        CFG_TOOL_OFFSET   = 3'd4
    } cfg_index_t;

    localparam logic [15:0] BASE_OFFSET_RST   = 16'd3277;
    localparam logic [15:0] COLUMN_HEIGHT_RST = 16'd29491;
    localparam logic [15:0] UPPER_ARM_RST     = 16'd27853;
    localparam logic [15:0] FOREARM_RST       = 16'd22610;
    localparam logic [15:0] TOOL_OFFSET_RST   = 16'd7209;

    // atan(2^-i) with 30 fraction bits
    function automatic logic signed [ZW-1:0] atan_q30(input int idx);
        logic signed [ZW-1:0] r;
        case (idx)
            0:  r = 34'sd843314856;
            1:  r = 34'sd497837829;
            2:  r = 34'sd263043836;
            3:  r = 34'sd133525158;
            4:  r = 34'sd67021686;
            5:  r = 34'sd33543515;
            6:  r = 34'sd16775850;
            7:  r = 34'sd8388437;
            8:  r = 34'sd4194282;
            9:  r = 34'sd2097149;
            10: r = 34'sd1048575;
            11: r = 34'sd524287;
            12: r = 34'sd262143;
            13: r = 34'sd131071;
            14: r = 34'sd65535;
            15: r = 34'sd32767;
            16: r = 34'sd16383;
            17: r = 34'sd8191;
            18: r = 34'sd4095;
            19: r = 34'sd2047;
            20: r = 34'sd1023;
            21: r = 34'sd511;
            22: r = 34'sd255;
            23: r = 34'sd127;
            24: r = 34'sd63;
            25: r = 34'sd31;
            26: r = 34'sd15;
            27: r = 34'sd8;
            28: r = 34'sd4;
            29: r = 34'sd2;
            30: r = 34'sd1;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

FILE: hdl/tlik_div_cell.sv
// One restoring-division cell: produces quotient bit K and hands the
// partial remainder to the next cell. Depends on nothing.
module tlik_div_cell #(
    parameter int DW = 33,
    parameter int QW = 17,
    parameter int K  = 16,
    parameter int PW = 1
)(
    input  logic          clk,
    input  logic          en,
    input  logic [DW-1:0] den_in,
    input  logic [DW-1:0] rem_in,
    input  logic [QW-1:0] quo_in,
    input  logic [PW-1:0] side_in,
    output logic [DW-1:0] den_out,
    output logic [DW-1:0] rem_out,
    output logic [QW-1:0] quo_out,
    output logic [PW-1:0] side_out
);

    logic [DW-1:0] den_reg;
    logic [DW-1:0] rem_reg;
    logic [QW-1:0] quo_reg;
    logic [PW-1:0] side_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    // top cell compares the remainder as is, the others shift it up first
    assign trial = (K == QW - 1) ? {1'b0, rem_in} : {rem_in, 1'b0};
    assign diff  = trial - {1'b0, den_in};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg  <= den_in;
            rem_reg  <= ge ? diff[DW-1:0] : trial[DW-1:0];
            quo_reg  <= ge ? (quo_in | (QW'(1) << K)) : quo_in;
            side_reg <= side_in;
        end
    end

    assign den_out  = den_reg;
    assign rem_out  = rem_reg;
    assign quo_out  = quo_reg;
    assign side_out = side_reg;

endmodule

FILE: hdl/tlik_sqrt_cell.sv
// One digit-by-digit square-root cell: decides root bit K and passes
// remainder and partial root on. Depends on nothing.
module tlik_sqrt_cell #(
    parameter int NW = 34,
    parameter int RW = 17,
    parameter int K  = 16,
    parameter int PW = 1
)(
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] rem_in,
    input  logic [RW-1:0] root_in,
    input  logic [PW-1:0] side_in,
    output logic [NW-1:0] rem_out,
    output logic [RW-1:0] root_out,
    output logic [PW-1:0] side_out
);

    localparam int NW1 = NW + 1;

    logic [NW-1:0]  rem_reg;
    logic [RW-1:0]  root_reg;
    logic [PW-1:0]  side_reg;
    logic [NW1-1:0] inc;
    logic [NW1-1:0] diff;
    logic           ge;

    // (root + 2^K)^2 - root^2 = root*2^(K+1) + 2^(2K)
    assign inc  = (NW1'(root_in) << (K + 1)) + (NW1'(1) << (2 * K));
    assign diff = {1'b0, rem_in} - inc;
    assign ge   = ({1'b0, rem_in} >= inc);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= ge ? diff[NW-1:0] : rem_in;
            root_reg <= ge ? (root_in | (RW'(1) << K)) : root_in;
            side_reg <= side_in;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule

FILE: hdl/tlik_cordic_cell.sv
// One CORDIC vectoring cell (iteration I): rotates toward the x axis and
// accumulates the angle. Depends on tlik_pkg.
module tlik_cordic_cell #(
    parameter int W  = 37,
    parameter int I  = 0,
    parameter int PW = 1
)(
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [W-1:0]          x_in,
    input  logic signed [W-1:0]          y_in,
    input  logic signed [tlik_pkg::ZW-1:0] z_in,
    input  logic [PW-1:0]                side_in,
    output logic signed [W-1:0]          x_out,
    output logic signed [W-1:0]          y_out,
    output logic signed [tlik_pkg::ZW-1:0] z_out,
    output logic [PW-1:0]                side_out
);

    localparam logic signed [tlik_pkg::ZW-1:0] ATAN_C = tlik_pkg::atan_q30(I);

    logic signed [W-1:0]           x_reg;
    logic signed [W-1:0]           y_reg;
    logic signed [tlik_pkg::ZW-1:0] z_reg;
    logic [PW-1:0]                 side_reg;
    logic signed [W-1:0]           dx;
    logic signed [W-1:0]           dy;

    // arithmetic shift is the floor of the scaled value
    assign dx = x_in >>> I;
    assign dy = y_in >>> I;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (!y_in[W-1])
            begin
                x_reg <= x_in + dy;
                y_reg <= y_in - dx;
                z_reg <= z_in + ATAN_C;
            end
            else
            begin
                x_reg <= x_in - dy;
                y_reg <= y_in + dx;
                z_reg <= z_in - ATAN_C;
            end
            side_reg <= side_in;
        end
    end

    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign side_out = side_reg;

endmodule

FILE: hdl/two_link_planar_ik_unit.sv
// Throughput: one target per cycle; the whole pipeline holds only while a result
// waits in the output register and the sink is not ready.
// Stage count is set by the divider chain (FRAC_BITS+1 cells), the root chain
// (FRAC_BITS+1 cells) and the CORDIC chains (CORDIC_STAGES cells).
// Reset (rst_n low, asynchronous) empties the pipeline and loads register defaults.
// Top level of the RRP arm inverse kinematics unit: front end, divider,
// square root and three CORDIC chains. Depends on tlik_pkg and the cell modules.
module two_link_planar_ik_unit #(
    parameter int FRAC_BITS     = tlik_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = tlik_pkg::CORDIC_STAGES_DEF
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,   // target_x, target_y, target_z, zero pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,   // shoulder_angle, elbow_angle,
                                                     // slide_travel, zero pad
    output logic [0:0]                    m_tuser,   // reach_clamped
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tlik_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                   cfg_data
);

    localparam int F   = FRAC_BITS;
    localparam int CS  = CORDIC_STAGES;
    localparam int QW  = F + 1;
    localparam int DW  = 33;
    localparam int CW  = F + 2;
    localparam int NW  = 2 * F + 2;
    localparam int RW  = F + 1;
    localparam int W   = F + 21;
    localparam int ZW  = tlik_pkg::ZW;
    localparam int SH  = tlik_pkg::ANG_FRAC - F;
    localparam int LAT = 2 * F + CS + 9;

    localparam logic signed [CW-1:0] ONE_C  = CW'(1) << F;
    localparam logic [ZW:0]          HALF_C = (ZW + 1)'(1) << (SH - 1);
    localparam logic signed [20:0]   TRAV_MAX = 21'sd262143;
    localparam logic signed [20:0]   TRAV_MIN = -21'sd262144;
    localparam logic signed [ZW:0]   Q1_MAX = 35'sd524287;
    localparam logic signed [ZW:0]   Q1_MIN = -35'sd524288;
    localparam logic signed [ZW:0]   Q2_MAX = 35'sd262143;

    typedef enum logic [1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_POS  = 2'd1,
        CLAMP_NEG  = 2'd2
    } clamp_t;

    typedef struct packed {
        logic signed [18:0] x;
        logic signed [18:0] y;
        logic signed [18:0] trav;
        logic [15:0]        a;
        logic [15:0]        b;
        clamp_t             clamp;
        logic               flag;
        logic               neg;
    } div_side_t;

    typedef struct packed {
        logic signed [18:0]   x;
        logic signed [18:0]   y;
        logic signed [18:0]   trav;
        logic [15:0]          a;
        logic [15:0]          b;
        logic                 flag;
        logic signed [CW-1:0] c;
    } sqrt_side_t;

    typedef struct packed {
        logic signed [W-1:0]  x;
        logic signed [W-1:0]  y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cordic_seed_t;

    localparam int DSW = $bits(div_side_t);
    localparam int SSW = $bits(sqrt_side_t);
    localparam int CSW = 21;

    // ------------------------------------------------------------------
    // Configuration registers
    logic [15:0] base_reg, column_reg, upper_reg, fore_reg, tool_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= tlik_pkg::BASE_OFFSET_RST;
            column_reg <= tlik_pkg::COLUMN_HEIGHT_RST;
            upper_reg  <= tlik_pkg::UPPER_ARM_RST;
            fore_reg   <= tlik_pkg::FOREARM_RST;
            tool_reg   <= tlik_pkg::TOOL_OFFSET_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tlik_pkg::CFG_BASE_OFFSET:   base_reg   <= cfg_data;
                tlik_pkg::CFG_COLUMN_HEIGHT: column_reg <= cfg_data;
                tlik_pkg::CFG_UPPER_ARM:     upper_reg  <= cfg_data;
                tlik_pkg::CFG_FOREARM:       fore_reg   <= cfg_data;
                tlik_pkg::CFG_TOOL_OFFSET:   tool_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: all stages move together unless the output stalls
    logic           adv;
    logic [LAT-1:0] vld_reg;
    logic           m_tvalid_reg;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg      <= {vld_reg[LAT-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[LAT-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: squares, link product, slide travel
    logic signed [18:0] in_x, in_y, in_z;
    logic signed [20:0] trav_w;
    logic signed [18:0] trav_sat;

    assign in_x = $signed(s_tdata[18:0]);
    assign in_y = $signed(s_tdata[37:19]);
    assign in_z = $signed(s_tdata[56:38]);

    always_comb
    begin
        trav_w = $signed({5'b0, base_reg}) + $signed({5'b0, column_reg})
               - $signed({5'b0, tool_reg}) - 21'(in_z);
        if (trav_w > TRAV_MAX)
            trav_sat = TRAV_MAX[18:0];
        else if (trav_w < TRAV_MIN)
            trav_sat = TRAV_MIN[18:0];
        else
            trav_sat = trav_w[18:0];
    end

    logic signed [37:0] s1_x2_reg, s1_y2_reg;
    logic [31:0]        s1_a2_reg, s1_b2_reg, s1_ab_reg;
    logic signed [18:0] s1_x_reg, s1_y_reg, s1_trav_reg;
    logic [15:0]        s1_a_reg, s1_b_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x2_reg   <= in_x * in_x;
            s1_y2_reg   <= in_y * in_y;
            s1_a2_reg   <= upper_reg * upper_reg;
            s1_b2_reg   <= fore_reg * fore_reg;
            s1_ab_reg   <= upper_reg * fore_reg;
            s1_x_reg    <= in_x;
            s1_y_reg    <= in_y;
            s1_trav_reg <= trav_sat;
            s1_a_reg    <= upper_reg;
            s1_b_reg    <= fore_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: cosine numerator and denominator, clamp decision
    logic signed [39:0] num;
    logic [DW-1:0]      den;
    logic signed [39:0] den_s;
    logic [39:0]        mag_w;
    clamp_t             clamp_c;
    logic               flag_c;

    always_comb
    begin
        num   = 40'(s1_x2_reg) + 40'(s1_y2_reg)
              - $signed({8'b0, s1_a2_reg}) - $signed({8'b0, s1_b2_reg});
        den   = {s1_ab_reg, 1'b0};
        den_s = $signed({7'b0, den});
        mag_w = num[39] ? 40'(-num) : 40'(num);
        if (den == '0)
        begin
            clamp_c = num[39] ? CLAMP_NEG : CLAMP_POS;
            flag_c  = 1'b1;
        end
        else if (num > den_s)
        begin
            clamp_c = CLAMP_POS;
            flag_c  = 1'b1;
        end
        else if (num < -den_s)
        begin
            clamp_c = CLAMP_NEG;
            flag_c  = 1'b1;
        end
        else
        begin
            clamp_c = CLAMP_NONE;
            flag_c  = 1'b0;
        end
    end

    logic [DW-1:0]  s2_den_reg, s2_rem_reg;
    logic [DSW-1:0] s2_side_reg;
    div_side_t      s2_side_c;

    always_comb
    begin
        s2_side_c.x     = s1_x_reg;
        s2_side_c.y     = s1_y_reg;
        s2_side_c.trav  = s1_trav_reg;
        s2_side_c.a     = s1_a_reg;
        s2_side_c.b     = s1_b_reg;
        s2_side_c.clamp = clamp_c;
        s2_side_c.flag  = flag_c;
        s2_side_c.neg   = num[39];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_den_reg  <= den;
            s2_rem_reg  <= mag_w[DW-1:0];
            s2_side_reg <= s2_side_c;
        end
    end

    // ------------------------------------------------------------------
    // Divider chain: one quotient bit per cell, MSB first
    logic [DW-1:0]  dv_den  [QW+1];
    logic [DW-1:0]  dv_rem  [QW+1];
    logic [QW-1:0]  dv_quo  [QW+1];
    logic [DSW-1:0] dv_side [QW+1];

    assign dv_den[0]  = s2_den_reg;
    assign dv_rem[0]  = s2_rem_reg;
    assign dv_quo[0]  = '0;
    assign dv_side[0] = s2_side_reg;

    for (genvar j = 0; j < QW; j++)
    begin : g_div
        tlik_div_cell #(
            .DW (DW),
            .QW (QW),
            .K  (QW - 1 - j),
            .PW (DSW)
        ) u_cell (
            .clk      (clk),
            .en       (adv),
            .den_in   (dv_den[j]),
            .rem_in   (dv_rem[j]),
            .quo_in   (dv_quo[j]),
            .side_in  (dv_side[j]),
            .den_out  (dv_den[j+1]),
            .rem_out  (dv_rem[j+1]),
            .quo_out  (dv_quo[j+1]),
            .side_out (dv_side[j+1])
        );
    end

    // ------------------------------------------------------------------
    // Stage 3: signed, clamped cosine
    div_side_t            dv_end;
    logic signed [CW-1:0] c_c;

    assign dv_end = div_side_t'(dv_side[QW]);

    always_comb
    begin
        case (dv_end.clamp)
            CLAMP_POS: c_c = ONE_C;
            CLAMP_NEG: c_c = -ONE_C;
            default:   c_c = dv_end.neg ? -$signed(CW'(dv_quo[QW]))
                                        : $signed(CW'(dv_quo[QW]));
        endcase
    end

    logic signed [CW-1:0] s3_c_reg;
    logic signed [18:0]   s3_x_reg, s3_y_reg, s3_trav_reg;
    logic [15:0]          s3_a_reg, s3_b_reg;
    logic                 s3_flag_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_c_reg    <= c_c;
            s3_x_reg    <= dv_end.x;
            s3_y_reg    <= dv_end.y;
            s3_trav_reg <= dv_end.trav;
            s3_a_reg    <= dv_end.a;
            s3_b_reg    <= dv_end.b;
            s3_flag_reg <= dv_end.flag;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: cosine squared
    logic signed [2*CW-1:0] cc_full;
    logic [NW-1:0]          s4_cc_reg;
    logic [SSW-1:0]         s4_side_reg;
    sqrt_side_t             s4_side_c;

    assign cc_full = s3_c_reg * s3_c_reg;

    always_comb
    begin
        s4_side_c.x    = s3_x_reg;
        s4_side_c.y    = s3_y_reg;
        s4_side_c.trav = s3_trav_reg;
        s4_side_c.a    = s3_a_reg;
        s4_side_c.b    = s3_b_reg;
        s4_side_c.flag = s3_flag_reg;
        s4_side_c.c    = s3_c_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_cc_reg   <= cc_full[NW-1:0];
            s4_side_reg <= s4_side_c;
        end
    end

    // ------------------------------------------------------------------
    // Square-root chain on 1 - c^2: one root bit per cell, MSB first
    logic [NW-1:0]  sq_rem  [RW+1];
    logic [RW-1:0]  sq_root [RW+1];
    logic [SSW-1:0] sq_side [RW+1];

    assign sq_rem[0]  = (NW'(1) << (2 * F)) - s4_cc_reg;
    assign sq_root[0] = '0;
    assign sq_side[0] = s4_side_reg;

    for (genvar j = 0; j < RW; j++)
    begin : g_sqrt
        tlik_sqrt_cell #(
            .NW (NW),
            .RW (RW),
            .K  (F - j),
            .PW (SSW)
        ) u_cell (
            .clk      (clk),
            .en       (adv),
            .rem_in   (sq_rem[j]),
            .root_in  (sq_root[j]),
            .side_in  (sq_side[j]),
            .rem_out  (sq_rem[j+1]),
            .root_out (sq_root[j+1]),
            .side_out (sq_side[j+1])
        );
    end

    // ------------------------------------------------------------------
    // Stage 5: forearm projections b*s and b*c
    sqrt_side_t              sq_end;
    logic [16+RW-1:0]        bs_c;
    logic signed [17+CW-1:0] bc_c;

    assign sq_end = sqrt_side_t'(sq_side[RW]);
    assign bs_c   = (16 + RW)'(sq_end.b) * (16 + RW)'(sq_root[RW]);
    assign bc_c   = (17 + CW)'($signed({1'b0, sq_end.b})) * (17 + CW)'(sq_end.c);

    logic [16+RW-1:0]        s5_bs_reg;
    logic signed [17+CW-1:0] s5_bc_reg;
    logic [RW-1:0]           s5_s_reg;
    logic signed [CW-1:0]    s5_c_reg;
    logic [15:0]             s5_a_reg;
    logic signed [18:0]      s5_x_reg, s5_y_reg, s5_trav_reg;
    logic                    s5_flag_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_bs_reg   <= bs_c;
            s5_bc_reg   <= bc_c;
            s5_s_reg    <= sq_root[RW];
            s5_c_reg    <= sq_end.c;
            s5_a_reg    <= sq_end.a;
            s5_x_reg    <= sq_end.x;
            s5_y_reg    <= sq_end.y;
            s5_trav_reg <= sq_end.trav;
            s5_flag_reg <= sq_end.flag;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: CORDIC seeds; left half-plane is folded over with +-pi
    function automatic cordic_seed_t cordic_seed(input logic signed [W-1:0] yv,
                                                 input logic signed [W-1:0] xv);
        cordic_seed_t r;
        r.zero = (xv == '0) && (yv == '0);
        if (xv[W-1])
        begin
            r.x = -xv;
            r.y = -yv;
            r.z = yv[W-1] ? -tlik_pkg::PI_Q30 : tlik_pkg::PI_Q30;
        end
        else
        begin
            r.x = xv;
            r.y = yv;
            r.z = '0;
        end
        return r;
    endfunction

    logic signed [W-1:0] ax_c;
    cordic_seed_t        seed_a, seed_b, seed_c;

    assign ax_c   = $signed(W'(s5_a_reg) << F) + W'(s5_bc_reg);
    assign seed_a = cordic_seed(W'(s5_y_reg), W'(s5_x_reg));
    assign seed_b = cordic_seed($signed(W'(s5_bs_reg)), ax_c);
    assign seed_c = cordic_seed($signed(W'(s5_s_reg)), W'(s5_c_reg));

    cordic_seed_t s6_a_reg, s6_b_reg, s6_c_reg;
    logic signed [18:0] s6_trav_reg;
    logic               s6_flag_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_a_reg    <= seed_a;
            s6_b_reg    <= seed_b;
            s6_c_reg    <= seed_c;
            s6_trav_reg <= s5_trav_reg;
            s6_flag_reg <= s5_flag_reg;
        end
    end

    // ------------------------------------------------------------------
    // Three CORDIC chains: target bearing, forearm offset angle, elbow angle
    logic signed [W-1:0]  ca_x [CS+1], cb_x [CS+1], cc_x [CS+1];
    logic signed [W-1:0]  ca_y [CS+1], cb_y [CS+1], cc_y [CS+1];
    logic signed [ZW-1:0] ca_z [CS+1], cb_z [CS+1], cc_z [CS+1];
    logic [0:0]           ca_side [CS+1];
    logic [0:0]           cb_side [CS+1];
    logic [CSW-1:0]       cc_side [CS+1];

    assign ca_x[0] = s6_a_reg.x;
    assign ca_y[0] = s6_a_reg.y;
    assign ca_z[0] = s6_a_reg.z;
    assign ca_side[0] = s6_a_reg.zero;
    assign cb_x[0] = s6_b_reg.x;
    assign cb_y[0] = s6_b_reg.y;
    assign cb_z[0] = s6_b_reg.z;
    assign cb_side[0] = s6_b_reg.zero;
    assign cc_x[0] = s6_c_reg.x;
    assign cc_y[0] = s6_c_reg.y;
    assign cc_z[0] = s6_c_reg.z;
    assign cc_side[0] = {s6_trav_reg, s6_flag_reg, s6_c_reg.zero};

    for (genvar i = 0; i < CS; i++)
    begin : g_cordic
        tlik_cordic_cell #(.W(W), .I(i), .PW(1)) u_bear (
            .clk (clk), .en (adv),
            .x_in (ca_x[i]), .y_in (ca_y[i]), .z_in (ca_z[i]), .side_in (ca_side[i]),
            .x_out (ca_x[i+1]), .y_out (ca_y[i+1]), .z_out (ca_z[i+1]),
            .side_out (ca_side[i+1])
        );
        tlik_cordic_cell #(.W(W), .I(i), .PW(1)) u_offs (
            .clk (clk), .en (adv),
            .x_in (cb_x[i]), .y_in (cb_y[i]), .z_in (cb_z[i]), .side_in (cb_side[i]),
            .x_out (cb_x[i+1]), .y_out (cb_y[i+1]), .z_out (cb_z[i+1]),
            .side_out (cb_side[i+1])
        );
        tlik_cordic_cell #(.W(W), .I(i), .PW(CSW)) u_elbow (
            .clk (clk), .en (adv),
            .x_in (cc_x[i]), .y_in (cc_y[i]), .z_in (cc_z[i]), .side_in (cc_side[i]),
            .x_out (cc_x[i+1]), .y_out (cc_y[i+1]), .z_out (cc_z[i+1]),
            .side_out (cc_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Stage 7: origin override and shoulder difference
    logic signed [ZW-1:0] za_c, zb_c, zc_c;

    assign za_c = ca_side[CS][0] ? '0 : ca_z[CS];
    assign zb_c = cb_side[CS][0] ? '0 : cb_z[CS];
    assign zc_c = cc_side[CS][0] ? '0 : cc_z[CS];

    logic signed [ZW:0]   s7_q1_reg;
    logic signed [ZW-1:0] s7_q2_reg;
    logic signed [18:0]   s7_trav_reg;
    logic                 s7_flag_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_q1_reg   <= (ZW + 1)'(za_c) - (ZW + 1)'(zb_c);
            s7_q2_reg   <= zc_c;
            s7_trav_reg <= cc_side[CS][CSW-1:2];
            s7_flag_reg <= cc_side[CS][1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: round half away from zero, saturate, output register
    function automatic logic signed [ZW:0] round_ang(input logic signed [ZW:0] v);
        logic [ZW:0] mag;
        mag = v[ZW] ? (ZW + 1)'(-v) : (ZW + 1)'(v);
        mag = (mag + HALF_C) >> SH;
        return v[ZW] ? -$signed(mag) : $signed(mag);
    endfunction

    logic signed [ZW:0] q1_r, q2_r;
    logic [19:0]        q1_sat;
    logic [17:0]        q2_sat;

    always_comb
    begin
        q1_r = round_ang(s7_q1_reg);
        q2_r = round_ang((ZW + 1)'(s7_q2_reg));
        if (q1_r > Q1_MAX)
            q1_sat = Q1_MAX[19:0];
        else if (q1_r < Q1_MIN)
            q1_sat = Q1_MIN[19:0];
        else
            q1_sat = q1_r[19:0];
        if (q2_r > Q2_MAX)
            q2_sat = Q2_MAX[17:0];
        else if (q2_r[ZW])
            q2_sat = '0;
        else
            q2_sat = q2_r[17:0];
    end

    logic [19:0] out_sh_reg;
    logic [17:0] out_el_reg;
    logic [18:0] out_tr_reg;
    logic        out_flag_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_sh_reg   <= q1_sat;
            out_el_reg   <= q2_sat;
            out_tr_reg   <= s7_trav_reg;
            out_flag_reg <= s7_flag_reg;
        end
    end

    assign m_tdata = {7'b0, out_tr_reg, out_el_reg, out_sh_reg};
    assign m_tuser = out_flag_reg;

    // ------------------------------------------------------------------
    // Assertions
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted transaction did not enter the pipeline");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!s_tready) |=> $stable(vld_reg))
        else $error("pipeline moved during an output stall");

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !vld_reg[LAT-1]) |=> !m_tvalid)
        else $error("result appeared without a transaction in the last stage");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_index == tlik_pkg::CFG_UPPER_ARM) |=>
        (upper_reg == $past(cfg_data)))
        else $error("upper arm length register not written");

endmodule
